### rtl/epp_hbc_pkg.sv
// ----------------------------------------------------------------------------
// EPP host byte cycle: shared package
// Counter width, handshake phases, saturated timing limits and the result
// record used by the host byte cycle unit and its parts.
// ----------------------------------------------------------------------------
package epp_hbc_pkg;

  // Width of the phase tick counter (legal range 4 to 32).
  localparam int TICK_COUNT_BITS = 16;
  localparam int CFG_BITS        = 16;
  localparam int CFG_IDX_BITS    = 2;

  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF >> (32 - TICK_COUNT_BITS);

  typedef logic [TICK_COUNT_BITS-1:0] cnt_t;
  typedef logic [CFG_BITS-1:0]        cfg_word_t;
  typedef logic [CFG_IDX_BITS-1:0]    cfg_idx_t;

  // Register indexes of the configuration port.
  localparam cfg_idx_t REG_SETUP    = 2'd0;
  localparam cfg_idx_t REG_STROBE   = 2'd1;
  localparam cfg_idx_t REG_RECOVERY = 2'd2;

  localparam cfg_word_t SETUP_RESET    = 16'd16;
  localparam cfg_word_t STROBE_RESET   = 16'd16;
  localparam cfg_word_t RECOVERY_RESET = 16'd80;

  localparam logic [7:0] IDLE_BYTE = 8'hFF;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_WAIT_LOW = 3'd1,
    PH_SETUP    = 3'd2,
    PH_STROBE   = 3'd3,
    PH_RECOVER  = 3'd4
  } phase_t;

  // Timing limits, already clipped to the counter range.
  typedef struct packed {
    cnt_t setup;
    cnt_t strobe;
    cnt_t recovery;
  } cfg_lim_t;

  typedef struct packed {
    logic       write_line;
    logic       data_strobe_line;
    logic       addr_strobe_line;
    logic       data_drive;
    logic [7:0] data_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
  } res_t;

  // Clip a register value to the largest count the counter can hold.
  function automatic cnt_t clip_ticks(cfg_word_t v);
    logic [31:0] w;
    w = 32'(v);
    if (w > CNT_MAX) begin
      w = CNT_MAX;
    end
    return cnt_t'(w);
  endfunction

endpackage

### rtl/epp_hbc_in_if.sv
// ----------------------------------------------------------------------------
// EPP host byte cycle: request channel
// One request per tick: optional byte cycle request plus sampled pin levels.
// ----------------------------------------------------------------------------
interface epp_hbc_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic       is_read;
  logic       is_address;
  logic       last_in_burst;
  logic [7:0] write_byte;
  logic       wait_line;
  logic [7:0] data_pins;

  modport source (
    output valid, action, is_read, is_address, last_in_burst, write_byte,
           wait_line, data_pins,
    input  ready
  );
  modport sink (
    input  valid, action, is_read, is_address, last_in_burst, write_byte,
           wait_line, data_pins,
    output ready
  );
endinterface

### rtl/epp_hbc_out_if.sv
// ----------------------------------------------------------------------------
// EPP host byte cycle: result channel
// Pin levels and status after each tick.
// ----------------------------------------------------------------------------
interface epp_hbc_out_if;
  logic       valid;
  logic       ready;
  logic       write_line;
  logic       data_strobe_line;
  logic       addr_strobe_line;
  logic       data_drive;
  logic [7:0] data_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;

  modport source (
    output valid, write_line, data_strobe_line, addr_strobe_line, data_drive,
           data_out, busy_res, done_res, read_byte,
    input  ready
  );
  modport sink (
    input  valid, write_line, data_strobe_line, addr_strobe_line, data_drive,
           data_out, busy_res, done_res, read_byte,
    output ready
  );
endinterface

### rtl/epp_hbc_cfg_if.sv
// ----------------------------------------------------------------------------
// EPP host byte cycle: configuration write channel
// Register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface epp_hbc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input  valid, index, data, output ready);
endinterface

### rtl/epp_hbc_cfg.sv
// ----------------------------------------------------------------------------
// EPP host byte cycle: timing registers
// Holds setup, strobe and recovery times, clipped to the counter range.
// ----------------------------------------------------------------------------
module epp_hbc_cfg
  import epp_hbc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  epp_hbc_cfg_if.sink   cfg_ch,
  output cfg_lim_t      lim
);

  cfg_lim_t lim_r;
  cfg_lim_t lim_nxt;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    lim_nxt = lim_r;
    if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        REG_SETUP:    lim_nxt.setup    = clip_ticks(cfg_ch.data);
        REG_STROBE:   lim_nxt.strobe   = clip_ticks(cfg_ch.data);
        REG_RECOVERY: lim_nxt.recovery = clip_ticks(cfg_ch.data);
        default:      lim_nxt = lim_r;  // unused index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r.setup    <= clip_ticks(SETUP_RESET);
      lim_r.strobe   <= clip_ticks(STROBE_RESET);
      lim_r.recovery <= clip_ticks(RECOVERY_RESET);
    end else begin
      lim_r <= lim_nxt;
    end
  end

  assign lim = lim_r;

endmodule

### rtl/epp_host_byte_cycle_unit.sv
// ----------------------------------------------------------------------------
// EPP host byte cycle unit
// Host side of the enhanced parallel port byte handshake, one tick per request.
// ----------------------------------------------------------------------------
// Each request on in_ch is one tick of the port: it carries the sampled nWAIT
// and data pin levels and may ask for one address or data byte cycle. The
// unit can take a request in every clock cycle and answers each with exactly
// one result on out_ch, holding the nWRITE, nDATASTB and nADDRSTB levels, the
// data drive enable and value, busy, a one-tick done pulse and the byte caught
// by the last read. The whole tick is evaluated by the phase sequencer between
// the state registers and the result register, so the rate is one request per
// cycle; in_ch.ready drops only while a result waits in the result register and
// out_ch.ready is low. Timing values must be written through cfg_ch (index 0
// setup, 1 strobe, 2 recovery) only while the unit is idle; the unit does not
// enforce this. Values beyond the counter range act as its maximum. Requests
// made during a byte cycle are ignored, and the waits on nWAIT never time out.
// ----------------------------------------------------------------------------
module epp_host_byte_cycle_unit
  import epp_hbc_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  epp_hbc_in_if.sink     in_ch,
  epp_hbc_out_if.source  out_ch,
  epp_hbc_cfg_if.sink    cfg_ch
);

  cfg_lim_t lim;

  // Handshake state
  phase_t     phase_r,        phase_nxt;
  cnt_t       tick_r,         tick_nxt;
  logic [7:0] held_byte_r,    held_byte_nxt;
  logic       held_read_r,    held_read_nxt;
  logic       held_addr_r,    held_addr_nxt;
  logic       held_last_r,    held_last_nxt;
  logic       burst_wr_r,     burst_wr_nxt;
  logic [7:0] captured_r,     captured_nxt;

  // Result register
  logic       out_valid_r,    out_valid_nxt;
  res_t       res_r,          res_nxt;

  logic       in_fire;
  logic       done;
  logic       strobing;
  cnt_t       tick_inc;
  cnt_t       tick_str;

  epp_hbc_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .lim    (lim)
  );

  // Accept a new tick whenever the result register is empty or being drained.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Setup and recovery counters wrap at the counter width; the strobe counter
  // stops at its minimum.
  assign tick_inc = tick_r + cnt_t'(1);
  assign tick_str = (tick_r < lim.strobe) ? tick_inc : tick_r;

  // Phase sequencer: next state of one tick
  always_comb begin
    phase_nxt     = phase_r;
    tick_nxt      = tick_r;
    held_byte_nxt = held_byte_r;
    held_read_nxt = held_read_r;
    held_addr_nxt = held_addr_r;
    held_last_nxt = held_last_r;
    burst_wr_nxt  = burst_wr_r;
    captured_nxt  = captured_r;
    done          = 1'b0;

    case (phase_r)
      PH_IDLE: begin
        if (in_ch.action) begin
          // Latch the request; a read closes any open write burst.
          held_read_nxt = in_ch.is_read;
          held_addr_nxt = in_ch.is_address;
          held_last_nxt = in_ch.last_in_burst;
          held_byte_nxt = in_ch.write_byte;
          burst_wr_nxt  = !in_ch.is_read;
          tick_nxt      = '0;
          phase_nxt     = PH_WAIT_LOW;
        end
      end
      PH_WAIT_LOW: begin
        if (!in_ch.wait_line) begin
          tick_nxt  = '0;
          phase_nxt = (!held_read_r && lim.setup != '0) ? PH_SETUP : PH_STROBE;
        end
      end
      PH_SETUP: begin
        tick_nxt = tick_inc;
        if (tick_inc >= lim.setup) begin
          tick_nxt  = '0;
          phase_nxt = PH_STROBE;
        end
      end
      PH_STROBE: begin
        tick_nxt = tick_str;
        // Release once the minimum is met and the peripheral raised nWAIT.
        if (tick_str >= lim.strobe && in_ch.wait_line) begin
          if (held_read_r) begin
            captured_nxt = in_ch.data_pins;
          end
          tick_nxt = '0;
          if (lim.recovery == '0) begin
            phase_nxt = PH_IDLE;
            if (!held_read_r && held_last_r) begin
              burst_wr_nxt = 1'b0;
            end
            done = 1'b1;
          end else begin
            phase_nxt = PH_RECOVER;
          end
        end
      end
      PH_RECOVER: begin
        tick_nxt = tick_inc;
        if (tick_inc >= lim.recovery) begin
          phase_nxt = PH_IDLE;
          tick_nxt  = '0;
          if (!held_read_r && held_last_r) begin
            burst_wr_nxt = 1'b0;
          end
          done = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        tick_nxt  = '0;
      end
    endcase
  end

  // Pin levels after the tick
  assign strobing = (phase_nxt == PH_STROBE);

  always_comb begin
    res_nxt.write_line       = !burst_wr_nxt;
    res_nxt.data_strobe_line = !(strobing && !held_addr_nxt);
    res_nxt.addr_strobe_line = !(strobing && held_addr_nxt);
    res_nxt.data_drive       = burst_wr_nxt;
    res_nxt.data_out         = IDLE_BYTE;
    if (!held_read_nxt && (phase_nxt inside {PH_SETUP, PH_STROBE, PH_RECOVER})) begin
      res_nxt.data_out = held_byte_nxt;
    end
    res_nxt.busy_res  = (phase_nxt != PH_IDLE);
    res_nxt.done_res  = done;
    res_nxt.read_byte = captured_nxt;
  end

  assign out_valid_nxt = in_fire || (out_valid_r && !out_ch.ready);

  // Advance state only on an accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      tick_r      <= '0;
      held_byte_r <= '0;
      held_read_r <= 1'b0;
      held_addr_r <= 1'b0;
      held_last_r <= 1'b0;
      burst_wr_r  <= 1'b0;
      captured_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        phase_r     <= phase_nxt;
        tick_r      <= tick_nxt;
        held_byte_r <= held_byte_nxt;
        held_read_r <= held_read_nxt;
        held_addr_r <= held_addr_nxt;
        held_last_r <= held_last_nxt;
        burst_wr_r  <= burst_wr_nxt;
        captured_r  <= captured_nxt;
      end
    end
  end

  // Result payload: load on accept, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.write_line       = res_r.write_line;
  assign out_ch.data_strobe_line = res_r.data_strobe_line;
  assign out_ch.addr_strobe_line = res_r.addr_strobe_line;
  assign out_ch.data_drive       = res_r.data_drive;
  assign out_ch.data_out         = res_r.data_out;
  assign out_ch.busy_res         = res_r.busy_res;
  assign out_ch.done_res         = res_r.done_res;
  assign out_ch.read_byte        = res_r.read_byte;

endmodule

### rtl/epp_hbc_chk.sv
// ----------------------------------------------------------------------------
// EPP host byte cycle: port checker
// Watches the result channel of the host byte cycle unit for illegal pin mixes.
// ----------------------------------------------------------------------------
module epp_hbc_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       write_line,
  input logic       data_strobe_line,
  input logic       addr_strobe_line,
  input logic       data_drive,
  input logic [7:0] data_out,
  input logic       busy_res,
  input logic       done_res
);

  // Hold a stalled result and its done flag.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(done_res) && $stable(data_out))
    else $error("result changed while stalled");

  // Never assert both strobes.
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> data_strobe_line || addr_strobe_line)
    else $error("both strobes low");

  // A strobe only inside a busy cycle, and never together with done.
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (!data_strobe_line || !addr_strobe_line) |-> busy_res && !done_res)
    else $error("strobe outside a byte cycle");

  // nWRITE low exactly while the lines are driven; undriven lines read 0xFF.
  a_drive_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (write_line != data_drive) && (data_drive || data_out == 8'hFF))
    else $error("nWRITE and data drive disagree");

endmodule

bind epp_host_byte_cycle_unit epp_hbc_chk u_epp_hbc_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .write_line       (out_ch.write_line),
  .data_strobe_line (out_ch.data_strobe_line),
  .addr_strobe_line (out_ch.addr_strobe_line),
  .data_drive       (out_ch.data_drive),
  .data_out         (out_ch.data_out),
  .busy_res         (out_ch.busy_res),
  .done_res         (out_ch.done_res)
);

### tb/tb_epp_host_byte_cycle_unit.sv
// ----------------------------------------------------------------------------
// EPP host byte cycle unit: self-checking testbench
// Drives port ticks (sampled nWAIT and data pins, optional byte cycle
// requests) into the unit and steps an internal model of the EPP host
// handshake once per accepted request. Every result on the output channel
// is compared field by field with the oldest predicted pin state. The
// timing registers are changed between phases, only while the port is idle,
// with both channels idling and stalling at random.
// ----------------------------------------------------------------------------
module tb_epp_host_byte_cycle_unit;
  import epp_hbc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Slowest run: about 1500 requests that may each wait out a gap and a stall.
  localparam int CYCLE_LIMIT = 1_000_000;

  // One port tick as the request channel carries it.
  typedef struct packed {
    logic       action;
    logic       is_read;
    logic       is_address;
    logic       last_in_burst;
    logic [7:0] write_byte;
    logic       wait_line;
    logic [7:0] data_pins;
  } tick_req_t;

  logic clk = 1'b0;
  logic rst_n;

  epp_hbc_in_if  in_ch();
  epp_hbc_out_if out_ch();
  epp_hbc_cfg_if cfg_ch();

  epp_host_byte_cycle_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Handshake model state: timing registers and the host port sequencer.
  // --------------------------------------------------------------------------
  cfg_word_t setup_reg    = SETUP_RESET;
  cfg_word_t strobe_reg   = STROBE_RESET;
  cfg_word_t recovery_reg = RECOVERY_RESET;

  phase_t     port_phase  = PH_IDLE;
  cnt_t       tick_cnt    = '0;
  logic [7:0] held_byte   = 8'h00;
  logic       held_read   = 1'b0;
  logic       held_addr   = 1'b0;
  logic       held_last   = 1'b0;
  logic       burst_open  = 1'b0;
  logic [7:0] caught_byte = 8'h00;

  // Requests waiting for the driver, and pin states waiting for the unit.
  tick_req_t pending_ticks[$];
  res_t      expected_pins[$];
  int        in_flight = 0;   // queued or presented, not yet accepted
  int        errors    = 0;
  int        cycles    = 0;

  // Register values beyond the counter range act as the counter maximum.
  function automatic cnt_t timing_limit(cfg_word_t v);
    return (32'(v) > CNT_MAX) ? cnt_t'(CNT_MAX) : cnt_t'(v);
  endfunction

  // Advance the host port by one tick and return the pins it shows after it.
  function automatic res_t advance_port_tick(tick_req_t r);
    res_t o;
    logic done;
    logic strobing;
    cnt_t setup_lim;
    cnt_t strobe_lim;
    cnt_t recov_lim;
    setup_lim  = timing_limit(setup_reg);
    strobe_lim = timing_limit(strobe_reg);
    recov_lim  = timing_limit(recovery_reg);
    done = 1'b0;
    case (port_phase)
      PH_IDLE: begin
        // Latch a new byte cycle; a read closes any open write burst.
        if (r.action) begin
          held_read  = r.is_read;
          held_addr  = r.is_address;
          held_last  = r.last_in_burst;
          held_byte  = r.write_byte;
          burst_open = !r.is_read;
          tick_cnt   = '0;
          port_phase = PH_WAIT_LOW;
        end
      end
      PH_WAIT_LOW: begin
        if (!r.wait_line) begin
          tick_cnt   = '0;
          port_phase = (!held_read && setup_lim != '0) ? PH_SETUP : PH_STROBE;
        end
      end
      PH_SETUP: begin
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= setup_lim) begin
          tick_cnt   = '0;
          port_phase = PH_STROBE;
        end
      end
      PH_STROBE: begin
        if (tick_cnt < strobe_lim) tick_cnt = tick_cnt + 1'b1;
        // Release once the minimum is met and the peripheral answers.
        if (tick_cnt >= strobe_lim && r.wait_line) begin
          if (held_read) caught_byte = r.data_pins;
          tick_cnt = '0;
          if (recov_lim == '0) begin
            port_phase = PH_IDLE;
            if (!held_read && held_last) burst_open = 1'b0;
            done = 1'b1;
          end else begin
            port_phase = PH_RECOVER;
          end
        end
      end
      PH_RECOVER: begin
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= recov_lim) begin
          port_phase = PH_IDLE;
          tick_cnt   = '0;
          if (!held_read && held_last) burst_open = 1'b0;
          done = 1'b1;
        end
      end
      default: begin
        port_phase = PH_IDLE;
        tick_cnt   = '0;
      end
    endcase

    strobing           = (port_phase == PH_STROBE);
    o.write_line       = !burst_open;
    o.data_strobe_line = !(strobing && !held_addr);
    o.addr_strobe_line = !(strobing && held_addr);
    o.data_drive       = burst_open;
    o.data_out         = IDLE_BYTE;
    if (!held_read && (port_phase == PH_SETUP || port_phase == PH_STROBE ||
                       port_phase == PH_RECOVER)) begin
      o.data_out = held_byte;
    end
    o.busy_res  = (port_phase != PH_IDLE);
    o.done_res  = done;
    o.read_byte = caught_byte;
    return o;
  endfunction

  // Idle length: mostly none or short, a few long, and now and then a calm
  // stretch with no idling at all.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(20, 150);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present queued requests, step the model on each accepted one.
  // --------------------------------------------------------------------------
  tick_req_t drive_req  = '0;
  logic      drive_on;
  int        send_gap   = 0;
  int        send_calm  = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      drive_on = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        expected_pins.push_back(advance_port_tick(drive_req));
        in_flight--;
        drive_on = 1'b0;
        send_gap = pick_gap(send_calm);
      end
      // Hold the current request until taken; load the next after any gap.
      if (!drive_on) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_ticks.size() > 0) begin
          drive_req = pending_ticks.pop_front();
          drive_on  = 1'b1;
        end
      end
      in_ch.valid         <= drive_on;
      in_ch.action        <= drive_req.action;
      in_ch.is_read       <= drive_req.is_read;
      in_ch.is_address    <= drive_req.is_address;
      in_ch.last_in_burst <= drive_req.last_in_burst;
      in_ch.write_byte    <= drive_req.write_byte;
      in_ch.wait_line     <= drive_req.wait_line;
      in_ch.data_pins     <= drive_req.data_pins;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: stall the result channel at random, check every taken result.
  // --------------------------------------------------------------------------
  res_t want;
  int   take_stall = 0;
  int   take_calm  = 0;

  function automatic void check_pin(string what, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pins.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, actual busy=%0b done=%0b",
                   $time, out_ch.busy_res, out_ch.done_res);
          errors++;
        end else begin
          want = expected_pins.pop_front();
          check_pin("write_line", 8'(want.write_line), 8'(out_ch.write_line));
          check_pin("data_strobe_line", 8'(want.data_strobe_line),
                    8'(out_ch.data_strobe_line));
          check_pin("addr_strobe_line", 8'(want.addr_strobe_line),
                    8'(out_ch.addr_strobe_line));
          check_pin("data_drive", 8'(want.data_drive), 8'(out_ch.data_drive));
          check_pin("data_out", want.data_out, out_ch.data_out);
          check_pin("busy_res", 8'(want.busy_res), 8'(out_ch.busy_res));
          check_pin("done_res", 8'(want.done_res), 8'(out_ch.done_res));
          check_pin("read_byte", want.read_byte, out_ch.read_byte);
        end
        take_stall = pick_gap(take_calm);
      end
      if (take_stall > 0) begin
        take_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: drop the run if the port hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic tick_req_t mk_tick(logic act, logic rd, logic adr, logic last,
                                        logic [7:0] wbyte, logic nwait, logic [7:0] pins);
    tick_req_t t;
    t.action        = act;
    t.is_read       = rd;
    t.is_address    = adr;
    t.last_in_burst = last;
    t.write_byte    = wbyte;
    t.wait_line     = nwait;
    t.data_pins     = pins;
    return t;
  endfunction

  // Random tick: low_pct is the chance of nWAIT low, req_pct of a request.
  function automatic tick_req_t rand_tick(int low_pct, int req_pct);
    tick_req_t t;
    t.action        = ($urandom_range(0, 99) < req_pct);
    t.is_read       = ($urandom_range(0, 2) == 0);
    t.is_address    = 1'($urandom_range(0, 1));
    t.last_in_burst = ($urandom_range(0, 99) < 35);
    t.write_byte    = 8'($urandom_range(0, 255));
    t.wait_line     = !($urandom_range(0, 99) < low_pct);
    t.data_pins     = 8'($urandom_range(0, 255));
    return t;
  endfunction

  task automatic queue_tick(tick_req_t t);
    pending_ticks.push_back(t);
    in_flight++;
  endtask

  // Wait until every queued request is taken and every result checked.
  task automatic drain();
    while (in_flight != 0 || expected_pins.size() != 0) @(posedge clk);
  endtask

  // Feed plain ticks until the modeled port is back in idle.
  task automatic settle_port();
    int low_pct;
    drain();
    while (port_phase != PH_IDLE) begin
      low_pct = $urandom_range(30, 70);
      repeat (64) queue_tick(rand_tick(low_pct, 0));
      drain();
    end
    // Let the unit go quiet before touching the registers.
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_word_t val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_SETUP:    setup_reg    = val;
      REG_STROBE:   strobe_reg   = val;
      REG_RECOVERY: recovery_reg = val;
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_timing(cfg_word_t s, cfg_word_t st, cfg_word_t rc);
    write_reg(REG_SETUP, s);
    write_reg(REG_STROBE, st);
    write_reg(REG_RECOVERY, rc);
  endtask

  // Random stream: nWAIT bias and request density change every 40 ticks so
  // some stretches run cycles quickly and others sit in the wait loops.
  task automatic random_run(int n);
    int low_pct;
    int req_pct;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        low_pct = $urandom_range(15, 85);
        req_pct = $urandom_range(5, 40);
      end
      queue_tick(rand_tick(low_pct, req_pct));
    end
    settle_port();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.action        = 1'b0;
    in_ch.is_read       = 1'b0;
    in_ch.is_address    = 1'b0;
    in_ch.last_in_burst = 1'b0;
    in_ch.write_byte    = 8'h00;
    in_ch.wait_line     = 1'b1;
    in_ch.data_pins     = 8'h00;
    out_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = REG_SETUP;
    cfg_ch.data         = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Run the reset timing first, before any register write.
    random_run(150);

    // Directed cycles with every timed phase skipped or minimal.
    set_timing(16'd0, 16'd0, 16'd0);
    queue_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1, 8'h00)); // idle tick
    // Address write of 0xFF, burst left open; nWAIT high holds the wait loop.
    queue_tick(mk_tick(1'b1, 1'b0, 1'b1, 1'b0, 8'hFF, 1'b1, 8'hFF));
    queue_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1, 8'h00));
    queue_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00));
    queue_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1, 8'h00));
    // Data read while the write burst is open: it closes the burst.
    queue_tick(mk_tick(1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00));
    queue_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00));
    // Request while busy: drop it.
    queue_tick(mk_tick(1'b1, 1'b0, 1'b1, 1'b1, 8'h55, 1'b0, 8'h3C));
    queue_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1, 8'hA5));
    // Data write of 0x00 marked last; a request on the completing tick is
    // ignored.
    queue_tick(mk_tick(1'b1, 1'b0, 1'b0, 1'b1, 8'h00, 1'b1, 8'hFF));
    queue_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'hFF));
    queue_tick(mk_tick(1'b1, 1'b1, 1'b1, 1'b0, 8'hFF, 1'b1, 8'hFF));
    // Two-byte write burst: data 0x80 then address 0x7F marked last.
    queue_tick(mk_tick(1'b1, 1'b0, 1'b0, 1'b0, 8'h80, 1'b0, 8'h00));
    queue_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00));
    queue_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1, 8'h00));
    queue_tick(mk_tick(1'b1, 1'b0, 1'b1, 1'b1, 8'h7F, 1'b1, 8'h00));
    queue_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00));
    queue_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1, 8'h00));
    // Address read catching 0x00 after 0xA5.
    queue_tick(mk_tick(1'b1, 1'b1, 1'b1, 1'b0, 8'hFF, 1'b1, 8'hFF));
    queue_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'hFF));
    queue_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1, 8'h00));
    settle_port();

    random_run(150);
    set_timing(16'd1, 16'd1, 16'd1);
    random_run(150);
    set_timing(16'd0, 16'd5, 16'd0);
    random_run(150);
    set_timing(16'd3, 16'd0, 16'd2);
    random_run(150);
    set_timing(cfg_word_t'($urandom_range(0, 6)), cfg_word_t'($urandom_range(0, 6)),
               cfg_word_t'($urandom_range(0, 6)));
    random_run(150);

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/epp_hbc_pkg.sv
rtl/epp_hbc_in_if.sv
rtl/epp_hbc_out_if.sv
rtl/epp_hbc_cfg_if.sv
rtl/epp_hbc_cfg.sv
rtl/epp_host_byte_cycle_unit.sv
rtl/epp_hbc_chk.sv
tb/tb_epp_host_byte_cycle_unit.sv
